// ----- rtl/bsp_point_locate_top_macros.svh -----
// assertion macros for the point locate block
`ifndef BSP_POINT_LOCATE_TOP_MACROS_SVH
`define BSP_POINT_LOCATE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BPL_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("bpl: invariant violated");
`define BPL_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("bpl: implication violated");
`define BPL_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("bpl: next-cycle check violated");
`else
`define BPL_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define BPL_ASSERT_IMP(label, clk, rst_n, pre, post)
`define BPL_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

// ----- rtl/bpl_pkg.sv -----
`default_nettype none
package bpl_pkg;

	localparam int NODE_SLOTS = 8192;
	localparam int SLOT_W     = $clog2(NODE_SLOTS);
	localparam int STEP_W     = $clog2(NODE_SLOTS + 1);
	localparam int COUNT_W    = 14;
	localparam int CHILD_W    = 16;
	localparam int LEAF_POS   = 15;
	localparam int SUB_W      = 15;
	localparam int ADDR_W     = 2;

	localparam logic [ADDR_W-1:0] ADDR_NODE_COUNT = 2'd0;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOCATE = 1'b1
	} op_t;

	typedef struct packed {
		logic [CHILD_W-1:0] back;
		logic [CHILD_W-1:0] front;
		logic signed [31:0] ddy;
		logic signed [31:0] ddx;
		logic signed [31:0] oy;
		logic signed [31:0] ox;
	} node_t;

	typedef struct packed {
		logic load;
		logic mul_r;
		logic mul_l;
	} side_ctl_t;

	typedef struct packed {
		logic early;
		logic side;
	} side_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_MUL_R,
		ST_MUL_L,
		ST_NEXT,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/bpl_if.sv -----
`default_nettype none
interface bpl_req_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [12:0]        node_slot;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [31:0] direction_x;
	logic signed [31:0] direction_y;
	logic [15:0]        front_child;
	logic [15:0]        back_child;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;

	modport source (
		output valid, operation, node_slot, origin_x, origin_y, direction_x,
			direction_y, front_child, back_child, point_x, point_y,
		input ready
	);
	modport sink (
		input valid, operation, node_slot, origin_x, origin_y, direction_x,
			direction_y, front_child, back_child, point_x, point_y,
		output ready
	);
endinterface

interface bpl_rsp_if;
	logic        valid;
	logic        ready;
	logic [14:0] subsector_index;
	logic        loop_error;

	modport source (output valid, subsector_index, loop_error, input ready);
	modport sink (input valid, subsector_index, loop_error, output ready);
endinterface
`default_nettype wire

// ----- rtl/bpl_ram.sv -----
`default_nettype none
module bpl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/bpl_side.sv -----
`default_nettype none
module bpl_side
	import bpl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic signed [31:0] px,
	input  wire logic signed [31:0] py,
	input  wire node_t              node,
	input  wire side_ctl_t          ctl,
	output side_sts_t               sts
);

	logic signed [31:0] dx, dy;
	logic               early, eside;
	logic               early_q, eside_q;
	logic signed [31:0] dx_q, dy_q, right_q, left_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic [31:0]        sgn;

	assign dx  = px - node.ox;
	assign dy  = py - node.oy;
	assign sgn = node.ddy ^ node.ddx ^ dx ^ dy;

	// special cases and sign shortcut
	always_comb begin
		early = 1'b1;
		eside = 1'b0;
		if (node.ddx == 32'sd0) begin
			eside = (px <= node.ox) ? (node.ddy > 32'sd0) : (node.ddy < 32'sd0);
		end else if (node.ddy == 32'sd0) begin
			eside = (py <= node.oy) ? (node.ddx < 32'sd0) : (node.ddx > 32'sd0);
		end else if (sgn[31]) begin
			eside = node.ddy[31] ^ dx[31];
		end else begin
			early = 1'b0;
		end
	end

	// single shared multiplier
	assign mul_a = ctl.mul_r ? dy_q : dx_q;
	assign mul_b = ctl.mul_r ? (node.ddx >>> 16) : (node.ddy >>> 16);
	assign prod  = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			early_q <= early;
			eside_q <= eside;
			dx_q    <= dx;
			dy_q    <= dy;
		end
		if (ctl.mul_r) begin
			right_q <= prod[47:16];
		end
		if (ctl.mul_l) begin
			left_q <= prod[47:16];
		end
	end

	assign sts.early = early;
	assign sts.side  = early_q ? eside_q : !(right_q < left_q);

endmodule
`default_nettype wire

// ----- rtl/bsp_point_locate_top.sv -----
// bsp point locate: write requests store a node when accepted and give no result
// locate: FETCH, LOAD, NEXT per node on the line or sign shortcut path, FETCH, LOAD, MUL_R,
// MUL_L, NEXT on the cross product, then FIN loads the result; one request at a time
// the node table (one single-port ram, registered read) and one multiplier set the rate
// asynchronous active-low reset clears the sequencer, node_count and result valid;
// table contents stay undefined until written
`default_nettype none
`include "bsp_point_locate_top_macros.svh"
module bsp_point_locate_top
	import bpl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	bpl_req_if.sink                request,
	bpl_rsp_if.source              result
);

	state_t               state_q, state_d;
	logic [COUNT_W-1:0]   node_count_q;
	logic [CHILD_W-1:0]   num_q, num_d;
	logic [STEP_W-1:0]    steps_q;
	logic                 zero_q;
	logic signed [31:0]   px_q, py_q;
	logic [SUB_W-1:0]     res_sub_q;
	logic                 res_loop_q;
	logic                 out_valid_q;
	logic [SUB_W-1:0]     out_sub_q;
	logic                 out_loop_q;

	logic                 ram_we, ram_re;
	logic [SLOT_W-1:0]    ram_addr;
	node_t                wr_node, rd_node, node;
	side_ctl_t            ctl;
	side_sts_t            sts;

	logic                 accept, start_locate, out_load, cfg_we;
	logic [31:0]          count_clamped;
	logic [CHILD_W-1:0]   start_num;
	logic                 slot_ok;

	// configuration
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr == ADDR_NODE_COUNT);
	always_comb begin
		prdata = '0;
		if (paddr == ADDR_NODE_COUNT) begin
			prdata = 32'(node_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_we) begin
			node_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign request.ready = (state_q == ST_IDLE);
	assign accept        = request.valid && request.ready;
	assign start_locate  = accept && (request.operation == OP_LOCATE);
	assign slot_ok       = 32'(request.node_slot) < NODE_SLOTS;

	assign count_clamped = (32'(node_count_q) > NODE_SLOTS) ? NODE_SLOTS
		: 32'(node_count_q);
	assign start_num     = CHILD_W'(count_clamped - 32'd1);

	assign wr_node.ox    = request.origin_x;
	assign wr_node.oy    = request.origin_y;
	assign wr_node.ddx   = request.direction_x;
	assign wr_node.ddy   = request.direction_y;
	assign wr_node.front = request.front_child;
	assign wr_node.back  = request.back_child;

	bpl_ram #(
		.WIDTH ($bits(node_t)),
		.DEPTH (NODE_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (wr_node),
		.rdata (rd_node)
	);

	// child beyond the table reads as an all-zero node
	assign node = zero_q ? node_t'('0) : rd_node;

	bpl_side u_side (
		.clk  (clk),
		.px   (px_q),
		.py   (py_q),
		.node (node),
		.ctl  (ctl),
		.sts  (sts)
	);

	assign num_d    = sts.side ? node.back : node.front;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || result.ready);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = SLOT_W'(num_q);
		ctl       = '0;
		case (state_q)
			ST_IDLE: begin
				ram_addr = SLOT_W'(request.node_slot);
				if (accept && request.operation == OP_WRITE) begin
					ram_we = slot_ok;
				end
				if (start_locate) begin
					state_d = (count_clamped == 32'd0) ? ST_FIN : ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (num_q[LEAF_POS] || steps_q == STEP_W'(NODE_SLOTS)) begin
					state_d = ST_FIN;
				end else begin
					ram_re  = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				ctl.load = 1'b1;
				state_d  = sts.early ? ST_NEXT : ST_MUL_R;
			end
			ST_MUL_R: begin
				ctl.mul_r = 1'b1;
				state_d   = ST_MUL_L;
			end
			ST_MUL_L: begin
				ctl.mul_l = 1'b1;
				state_d   = ST_NEXT;
			end
			ST_NEXT: begin
				state_d = ST_FETCH;
			end
			ST_FIN: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q    <= '0;
			num_q      <= '0;
			zero_q     <= 1'b0;
			res_sub_q  <= '0;
			res_loop_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_locate) begin
						num_q      <= start_num;
						steps_q    <= '0;
						res_sub_q  <= '0;
						res_loop_q <= 1'b0;
					end
				end
				ST_FETCH: begin
					if (num_q[LEAF_POS]) begin
						res_sub_q <= num_q[SUB_W-1:0];
					end else if (steps_q == STEP_W'(NODE_SLOTS)) begin
						res_loop_q <= 1'b1;
					end else begin
						steps_q <= steps_q + 1'b1;
						zero_q  <= 32'(num_q[SUB_W-1:0]) >= NODE_SLOTS;
					end
				end
				ST_NEXT: begin
					num_q <= num_d;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_locate) begin
			px_q <= request.point_x;
			py_q <= request.point_y;
		end
		if (out_load) begin
			out_sub_q  <= res_sub_q;
			out_loop_q <= res_loop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.subsector_index = out_sub_q;
	assign result.loop_error      = out_loop_q;

	`BPL_ASSERT_ALWAYS(a_steps_bound, clk, arst_n, steps_q <= STEP_W'(NODE_SLOTS))
	`BPL_ASSERT_IMP(a_loop_zero, clk, arst_n, result.valid && result.loop_error, result.subsector_index == '0)
	`BPL_ASSERT_NXT(a_write_no_walk, clk, arst_n, accept && request.operation == OP_WRITE, state_q == ST_IDLE)

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
	import bpl_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 4_000_000;

	typedef struct {
		op_t                op;
		logic [SLOT_W-1:0]  slot;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] ddx;
		logic signed [31:0] ddy;
		logic [CHILD_W-1:0] front;
		logic [CHILD_W-1:0] back;
		logic signed [31:0] px;
		logic signed [31:0] py;
	} bsp_request_t;

	typedef struct {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] ddx;
		logic signed [31:0] ddy;
		logic [CHILD_W-1:0] front;
		logic [CHILD_W-1:0] back;
	} part_node_t;

	typedef struct {
		logic [SUB_W-1:0] sub;
		logic             loop_err;
	} leaf_answer_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	bpl_req_if request_ch ();
	bpl_rsp_if result_ch ();

	bsp_point_locate_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.request(request_ch),
		.result(result_ch)
	);

	part_node_t         node_mem [NODE_SLOTS];
	logic [COUNT_W-1:0] count_cfg;
	leaf_answer_t       expected_leaves [$];
	leaf_answer_t       head_leaf;
	int unsigned        send_idle_pct;
	int unsigned        recv_idle_pct;
	int unsigned        items_sent;
	int unsigned        tree_lo;
	int unsigned        tree_hi;
	int unsigned        cycle_count;
	int                 fail_count;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_leaves.size() == 0) begin
				$error("result with no pending locate: subsector_index %0d loop_error %0d",
					result_ch.subsector_index, result_ch.loop_error);
				fail_count++;
			end else begin
				head_leaf = expected_leaves.pop_front();
				if (result_ch.subsector_index !== head_leaf.sub) begin
					$error("subsector_index mismatch: expected %0d, got %0d",
						head_leaf.sub, result_ch.subsector_index);
					fail_count++;
				end
				if (result_ch.loop_error !== head_leaf.loop_err) begin
					$error("loop_error mismatch: expected %0d, got %0d",
						head_leaf.loop_err, result_ch.loop_error);
					fail_count++;
				end
			end
		end
	end

	function automatic logic signed [31:0] fixed_mul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		longint prod;
		prod = longint'(a) * longint'(b);
		return prod[47:16];
	endfunction

	function automatic logic line_side(input logic signed [31:0] px,
		input logic signed [31:0] py, input part_node_t nd);
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] lhs;
		logic signed [31:0] rhs;
		logic [31:0]        mix;
		if (nd.ddx == 0)
			return (px <= nd.ox) ? (nd.ddy > 0) : (nd.ddy < 0);
		if (nd.ddy == 0)
			return (py <= nd.oy) ? (nd.ddx < 0) : (nd.ddx > 0);
		dx = px - nd.ox;
		dy = py - nd.oy;
		mix = nd.ddy ^ nd.ddx ^ dx ^ dy;
		if (mix[31])
			return nd.ddy[31] ^ dx[31];
		lhs = fixed_mul(nd.ddy >>> 16, dx);
		rhs = fixed_mul(dy, nd.ddx >>> 16);
		return !(rhs < lhs);
	endfunction

	function automatic leaf_answer_t locate_leaf(input logic signed [31:0] px,
		input logic signed [31:0] py);
		leaf_answer_t       ans;
		part_node_t         nd;
		logic [CHILD_W-1:0] num;
		int unsigned        start;
		int unsigned        steps;
		ans.sub = '0;
		ans.loop_err = 1'b0;
		start = (count_cfg > NODE_SLOTS) ? NODE_SLOTS : count_cfg;
		if (start == 0)
			return ans;
		num = CHILD_W'(start - 1);
		steps = 0;
		while (!num[LEAF_POS]) begin
			if (steps >= NODE_SLOTS) begin
				ans.loop_err = 1'b1;
				return ans;
			end
			steps++;
			nd = '{default: '0};
			if (num < NODE_SLOTS)
				nd = node_mem[num];
			num = line_side(px, py, nd) ? nd.back : nd.front;
		end
		ans.sub = num[SUB_W-1:0];
		return ans;
	endfunction

	function automatic logic signed [31:0] near_offset();
		return int'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
	endfunction

	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(15))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2, 3, 4: return near_offset();
			5, 6, 7: return (int'($urandom_range(0, 2047)) - 1024) * 65536;
			default: return $urandom();
		endcase
	endfunction

	// tree nodes point to leaves, to children beyond the table or to lower slots of their own tree
	function automatic logic [CHILD_W-1:0] pick_child(input int unsigned s, input bit in_tree);
		int unsigned r;
		r = $urandom_range(9);
		if (in_tree && r >= 5 && s > tree_lo)
			return CHILD_W'($urandom_range(tree_lo, s - 1));
		if (r == 4 && s > 0)
			return CHILD_W'($urandom_range(NODE_SLOTS, 16'h7FFF));
		return 16'h8000 | CHILD_W'($urandom_range(16'h7FFF));
	endfunction

	function automatic bsp_request_t make_node_write(input int unsigned s, input bit in_tree);
		bsp_request_t rq;
		rq.op = OP_WRITE;
		rq.slot = SLOT_W'(s);
		rq.ox = pick_coord();
		rq.oy = pick_coord();
		rq.ddx = pick_coord();
		rq.ddy = pick_coord();
		case ($urandom_range(19))
			0, 1, 2: rq.ddx = 0;
			3, 4, 5: rq.ddy = 0;
			6: begin
				rq.ddx = 0;
				rq.ddy = 0;
			end
			default: ;
		endcase
		rq.front = pick_child(s, in_tree);
		rq.back = pick_child(s, in_tree);
		rq.px = $urandom();
		rq.py = $urandom();
		return rq;
	endfunction

	function automatic bsp_request_t make_locate();
		bsp_request_t rq;
		int unsigned  k;
		rq.op = OP_LOCATE;
		rq.slot = SLOT_W'($urandom_range(NODE_SLOTS - 1));
		rq.ox = $urandom();
		rq.oy = $urandom();
		rq.ddx = $urandom();
		rq.ddy = $urandom();
		rq.front = CHILD_W'($urandom());
		rq.back = CHILD_W'($urandom());
		if ($urandom_range(1)) begin
			k = $urandom_range(tree_lo, tree_hi);
			rq.px = node_mem[k].ox + near_offset();
			rq.py = node_mem[k].oy + near_offset();
		end else begin
			rq.px = pick_coord();
			rq.py = pick_coord();
		end
		return rq;
	endfunction

	task automatic send_request(input bsp_request_t rq);
		while ($urandom_range(99) < send_idle_pct) begin
			request_ch.valid <= 1'b0;
			@(negedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.operation <= rq.op;
		request_ch.node_slot <= rq.slot;
		request_ch.origin_x <= rq.ox;
		request_ch.origin_y <= rq.oy;
		request_ch.direction_x <= rq.ddx;
		request_ch.direction_y <= rq.ddy;
		request_ch.front_child <= rq.front;
		request_ch.back_child <= rq.back;
		request_ch.point_x <= rq.px;
		request_ch.point_y <= rq.py;
		do @(posedge clk); while (request_ch.ready !== 1'b1);
		if (rq.op == OP_WRITE)
			node_mem[rq.slot] = '{rq.ox, rq.oy, rq.ddx, rq.ddy, rq.front, rq.back};
		else
			expected_leaves.push_back(locate_leaf(rq.px, rq.py));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle_block();
		request_ch.valid <= 1'b0;
		while (expected_leaves.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_node_count(input int unsigned value);
		settle_block();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_NODE_COUNT;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		count_cfg = COUNT_W'(value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic node_write(input int unsigned s, input logic signed [31:0] ox,
		input logic signed [31:0] oy, input logic signed [31:0] ddx,
		input logic signed [31:0] ddy, input logic [CHILD_W-1:0] front,
		input logic [CHILD_W-1:0] back);
		bsp_request_t rq;
		rq = make_node_write(s, 1'b0);
		rq.ox = ox;
		rq.oy = oy;
		rq.ddx = ddx;
		rq.ddy = ddy;
		rq.front = front;
		rq.back = back;
		send_request(rq);
	endtask

	task automatic locate_at(input logic signed [31:0] px, input logic signed [31:0] py);
		bsp_request_t rq;
		rq = make_locate();
		rq.px = px;
		rq.py = py;
		send_request(rq);
	endtask

	task automatic test_empty_tree();
		write_node_count(0);
		locate_at(32'sh80000000, 32'sh7FFFFFFF);
	endtask

	task automatic test_vertical_line();
		node_write(0, 0, 32'sh7FFFFFFF, 0, 32'sh00010000, 16'hFFFF, 16'h8000);
		write_node_count(1);
		locate_at(0, 5);
		locate_at(1, 32'sh80000000);
	endtask

	task automatic test_horizontal_line();
		node_write(0, 32'sh80000000, 0, 32'sh80000000, 0, 16'h8001, 16'hAAAA);
		locate_at(32'sh7FFFFFFF, 0);
		locate_at(0, 32'sh7FFFFFFF);
	endtask

	task automatic test_degenerate_line();
		node_write(0, 32'sh12345678, 32'shEDCBA987, 0, 0, 16'hD555, 16'hC000);
		locate_at(32'sh80000000, 32'sh80000000);
		locate_at(32'sh7FFFFFFF, 32'sh7FFFFFFF);
	endtask

	task automatic test_sign_shortcut();
		node_write(0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 16'h8011, 16'h8022);
		locate_at(5, 5);
		locate_at(-5, -5);
	endtask

	task automatic test_cross_product();
		node_write(0, 0, 0, 32'sh00030000, 32'sh00010000, 16'h8033, 16'h8044);
		locate_at(32'sh00060000, 32'sh00010000);
		locate_at(32'sh00010000, 32'sh00010000);
		// on the line: equal products go to the back child
		locate_at(32'sh00030000, 32'sh00010000);
	endtask

	task automatic test_child_beyond_table();
		node_write(1, 5, 5, 0, 0, 16'h7FFF, 16'h8000);
		write_node_count(2);
		locate_at(32'sh00020000, 32'sh00050000);
	endtask

	task automatic test_step_limit();
		node_write(1, 0, 0, 0, 0, 16'h0001, 16'h0001);
		locate_at(7, 9);
		node_write(1, 0, 0, 0, 0, 16'h8123, 16'h8456);
	endtask

	task automatic test_count_beyond_table();
		node_write(NODE_SLOTS - 1, 0, 0, 32'sh00010000, 32'shFFFF0000, 16'h8777, 16'hFFFE);
		write_node_count(NODE_SLOTS);
		locate_at(32'sh00040000, 32'sh00010000);
		write_node_count(16383);
		locate_at(32'shFFFC0000, 32'sh00010000);
	endtask

	task automatic plant_tree(input int unsigned lo, input int unsigned n);
		tree_lo = lo;
		tree_hi = lo + n - 1;
		for (int unsigned s = lo; s <= tree_hi; s++)
			send_request(make_node_write(s, 1'b1));
	endtask

	task automatic run_session();
		int unsigned  n;
		int unsigned  lo;
		int unsigned  s;
		int unsigned  r;
		int unsigned  cnt;
		bsp_request_t rq;
		n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		lo = ($urandom_range(5) == 0) ? NODE_SLOTS - n : $urandom_range(0, NODE_SLOTS - n);
		plant_tree(lo, n);
		if ($urandom_range(9) == 0)
			cnt = 0;
		else if (tree_hi == NODE_SLOTS - 1)
			cnt = $urandom_range(1) ? 16383 : $urandom_range(NODE_SLOTS, 16383);
		else
			cnt = tree_hi + 1;
		write_node_count(cnt);
		repeat ($urandom_range(20, 60)) begin
			r = $urandom_range(19);
			if (r < 2) begin
				rq = make_node_write($urandom_range(tree_lo, tree_hi), 1'b1);
			end else if (r < 4) begin
				s = $urandom_range(NODE_SLOTS - 1);
				rq = make_node_write(s, s >= tree_lo && s <= tree_hi);
			end else begin
				rq = make_locate();
			end
			send_request(rq);
		end
	endtask

	task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct,
		input int unsigned goal);
		int unsigned stop_at;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at = items_sent + goal;
		while (items_sent < stop_at)
			run_session();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		request_ch.valid = 1'b0;
		request_ch.operation = OP_WRITE;
		request_ch.node_slot = '0;
		request_ch.origin_x = '0;
		request_ch.origin_y = '0;
		request_ch.direction_x = '0;
		request_ch.direction_y = '0;
		request_ch.front_child = '0;
		request_ch.back_child = '0;
		request_ch.point_x = '0;
		request_ch.point_y = '0;
		result_ch.ready = 1'b0;
		count_cfg = '0;
		send_idle_pct = 33;
		recv_idle_pct = 88;
		items_sent = 0;
		tree_lo = 0;
		tree_hi = 0;
		cycle_count = 0;
		fail_count = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_tree();
		test_vertical_line();
		test_horizontal_line();
		test_degenerate_line();
		test_sign_shortcut();
		test_cross_product();
		test_child_beyond_table();
		test_step_limit();
		test_count_beyond_table();

		test_random(33, 88, 460);
		test_random(88, 33, 460);
		test_random(0, 0, 460);

		settle_block();
		repeat (32) @(negedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
